// ===== rtl/core/lz4bd_pkg.sv =====
// Shared types and constants for the LZ4 block decoder.
// No dependencies; every other file of the decoder but lz4bd_ram uses this package.
package lz4bd_pkg;

  localparam int COUNT_BITS = 25;
  localparam int FIND_BITS  = 24;
  localparam int HIST_BYTES = 65536;
  localparam int HIST_AW    = $clog2(HIST_BYTES);
  localparam int CFG_BITS   = 25;

  typedef enum logic [1:0] {
    FN_BYTE = 2'd0,
    FN_TICK = 2'd1,
    FN_END  = 2'd2,
    FN_RSVD = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_RUN        = 3'd0,
    ST_OK         = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_BAD_OFFSET = 3'd3,
    ST_TRUNCATED  = 3'd4,
    ST_SIZE       = 3'd5,
    ST_BAD_REQ    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_OUT_SIZE = 2'd0,
    CFG_FIND_POS = 2'd1,
    CFG_LOCATE   = 2'd2
  } cfg_idx_t;

  // One item as it leaves the control stage.
  typedef struct packed {
    logic                 emit_lit;
    logic                 emit_match;
    logic [7:0]           lit_byte;
    logic [HIST_AW-1:0]   rd_addr;
    logic [HIST_AW-1:0]   wr_addr;
    logic                 copy_pending;
    status_t              status;
    logic                 found;
    logic [FIND_BITS-1:0] found_index;
    logic                 block_done;
  } item_t;

endpackage

// ===== rtl/core/lz4bd_req_if.sv =====
// Compressed-side channel: valid/ready plus function code and byte.
// Depends on lz4bd_pkg.
interface lz4bd_req_if;
  logic                  valid;
  logic                  ready;
  lz4bd_pkg::func_t      func;
  logic [7:0]            in_byte;

  modport source (output valid, func, in_byte, input ready);
  modport sink (input valid, func, in_byte, output ready);
endinterface

// ===== rtl/core/lz4bd_rsp_if.sv =====
// Result channel: valid/ready plus decoded byte and status fields.
// Depends on lz4bd_pkg.
interface lz4bd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [7:0]                       out_byte;
  logic                             out_valid;
  logic                             copy_pending;
  lz4bd_pkg::status_t               status;
  logic                             found;
  logic [lz4bd_pkg::FIND_BITS-1:0]  found_index;
  logic                             block_done;

  modport source (output valid, out_byte, out_valid, copy_pending, status, found,
                  found_index, block_done, input ready);
  modport sink (input valid, out_byte, out_valid, copy_pending, status, found,
                found_index, block_done, output ready);
endinterface

// ===== rtl/core/lz4bd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lz4bd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/lz4bd_ctrl.sv =====
// Parse and control stage: token/length/offset sequencing, counters, errors,
// configuration registers. Depends on lz4bd_pkg.
module lz4bd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  lz4bd_pkg::func_t              func,
  input  logic [7:0]                    in_byte,
  input  logic                          cfg_we,
  input  lz4bd_pkg::cfg_idx_t           cfg_addr,
  input  logic [lz4bd_pkg::CFG_BITS-1:0] cfg_data,
  output lz4bd_pkg::item_t              item
);
  import lz4bd_pkg::*;

  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [16:0] HIST_LIM = 17'(HIST_BYTES);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LIT_EXT, PH_LIT, PH_OFF_LO, PH_OFF_HI, PH_MAT_EXT, PH_COPY, PH_HALT
  } phase_t;

  logic [CW-1:0]        out_size;
  logic [FIND_BITS-1:0] find_pos;
  logic                 locate_only;

  phase_t               phase, phase_next;
  logic [CW-1:0]        literal_left, literal_left_next;
  logic [CW-1:0]        match_left, match_left_next;
  logic [3:0]           match_nibble, match_nibble_next;
  logic [15:0]          back_offset, back_offset_next;
  logic [CW-1:0]        out_count, out_count_next;
  logic [CW-1:0]        in_count, in_count_next;
  logic                 found_flag, found_flag_next;
  logic [FIND_BITS-1:0] found_src, found_src_next;
  status_t              error_code, error_code_next;

  logic [CW:0]   lit_sum, mat_sum, sm_len;
  logic [CW+1:0] sm_end;
  logic          loc_bad, off_bad;
  status_t       end_st;

  assign loc_bad = locate_only && ({1'b0, find_pos} >= out_size);
  assign lit_sum = {1'b0, literal_left} + (CW+1)'(in_byte);
  assign mat_sum = {1'b0, match_left} + (CW+1)'(in_byte);
  assign sm_len  = (phase == PH_MAT_EXT) ? mat_sum + (CW+1)'(4)
                                         : (CW+1)'(match_nibble) + (CW+1)'(4);
  assign sm_end  = {1'b0, out_count} + {1'b0, sm_len};
  assign off_bad = (back_offset == '0) || (CW'(back_offset) > out_count) ||
                   ({1'b0, back_offset} > HIST_LIM);

  always_comb begin
    if (phase == PH_HALT) end_st = error_code;
    else if (loc_bad) end_st = ST_BAD_REQ;
    else begin
      case (phase)
        PH_TOKEN, PH_OFF_LO: begin
          end_st = (!locate_only && out_count == out_size) ? ST_OK : ST_SIZE;
        end
        PH_COPY: end_st = ST_BAD_REQ;
        default: end_st = ST_TRUNCATED;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    literal_left_next = literal_left;
    match_left_next   = match_left;
    match_nibble_next = match_nibble;
    back_offset_next  = back_offset;
    out_count_next    = out_count;
    in_count_next     = in_count;
    found_flag_next   = found_flag;
    found_src_next    = found_src;
    error_code_next   = error_code;
    item              = '0;
    item.lit_byte     = in_byte;
    item.rd_addr      = out_count[HIST_AW-1:0] - back_offset[HIST_AW-1:0];
    item.wr_addr      = out_count[HIST_AW-1:0];

    if (func == FN_END) begin
      phase_next        = PH_TOKEN;
      literal_left_next = '0;
      match_left_next   = '0;
      match_nibble_next = '0;
      back_offset_next  = '0;
      out_count_next    = '0;
      in_count_next     = '0;
      found_flag_next   = 1'b0;
      found_src_next    = '0;
      error_code_next   = ST_RUN;
    end else if (phase != PH_HALT) begin
      if (func == FN_RSVD || loc_bad) begin
        phase_next = PH_HALT; error_code_next = ST_BAD_REQ;
      end else if (func == FN_BYTE) begin
        if (in_count == CMAX) begin
          phase_next = PH_HALT; error_code_next = ST_OVERFLOW;
        end else begin
          in_count_next = in_count + CW'(1);
          case (phase)
            PH_TOKEN: begin
              match_nibble_next = in_byte[3:0];
              literal_left_next = CW'(in_byte[7:4]);
              if (in_byte[7:4] == 4'hF) phase_next = PH_LIT_EXT;
              else if (in_byte[7:4] != 4'h0) phase_next = PH_LIT;
              else phase_next = PH_OFF_LO;
            end
            PH_LIT_EXT: begin
              literal_left_next = lit_sum[CW-1:0];
              if (lit_sum[CW]) begin
                phase_next = PH_HALT; error_code_next = ST_OVERFLOW;
              end else if (in_byte != 8'hFF) phase_next = PH_LIT;
            end
            PH_LIT: begin
              if (out_count >= out_size) begin
                phase_next = PH_HALT; error_code_next = ST_OVERFLOW;
              end else begin
                if (out_count == {1'b0, find_pos} && !found_flag) begin
                  found_flag_next = 1'b1;
                  found_src_next  = in_count[FIND_BITS-1:0];
                end
                item.emit_lit     = 1'b1;
                out_count_next    = out_count + CW'(1);
                literal_left_next = literal_left - CW'(1);
                if (literal_left == CW'(1)) begin
                  if (locate_only && out_count >= {1'b0, find_pos}) begin
                    phase_next = PH_HALT; error_code_next = ST_OK;
                  end else phase_next = PH_OFF_LO;
                end
              end
            end
            PH_OFF_LO: begin
              back_offset_next = {8'h00, in_byte};
              phase_next       = PH_OFF_HI;
            end
            PH_OFF_HI, PH_MAT_EXT: begin
              if (phase == PH_OFF_HI) back_offset_next = {in_byte, back_offset[7:0]};
              else match_left_next = mat_sum[CW-1:0];
              if (phase == PH_OFF_HI && match_nibble == 4'hF) begin
                match_left_next = CW'(15);
                phase_next      = PH_MAT_EXT;
              end else if (phase == PH_MAT_EXT && mat_sum[CW]) begin
                phase_next = PH_HALT; error_code_next = ST_OVERFLOW;
              end else if (phase == PH_OFF_HI || in_byte != 8'hFF) begin
                // offset checks use the full offset, so recompute it on the high byte
                if ((phase == PH_OFF_HI) ?
                    ({in_byte, back_offset[7:0]} == 16'h0 ||
                     CW'({in_byte, back_offset[7:0]}) > out_count ||
                     {1'b0, in_byte, back_offset[7:0]} > HIST_LIM) : off_bad) begin
                  phase_next = PH_HALT; error_code_next = ST_BAD_OFFSET;
                end else if (sm_end > {2'b00, out_size}) begin
                  phase_next = PH_HALT; error_code_next = ST_OVERFLOW;
                end else if (locate_only && sm_end > (CW+2)'(find_pos)) begin
                  phase_next = PH_HALT; error_code_next = ST_OK;
                end else begin
                  match_left_next = sm_len[CW-1:0];
                  phase_next      = PH_COPY;
                end
              end
            end
            default: begin
              phase_next = PH_HALT; error_code_next = ST_BAD_REQ;
            end
          endcase
        end
      end else if (phase == PH_COPY) begin
        item.emit_match = 1'b1;
        out_count_next  = out_count + CW'(1);
        match_left_next = match_left - CW'(1);
        if (match_left == CW'(1)) phase_next = PH_TOKEN;
      end else begin
        phase_next = PH_HALT; error_code_next = ST_BAD_REQ;
      end
    end

    if (func == FN_END) begin
      item.status      = end_st;
      item.found       = found_flag;
      item.found_index = found_flag ? found_src : '0;
      item.block_done  = 1'b1;
    end else begin
      item.copy_pending = (phase_next == PH_COPY) && (match_left_next != '0);
      item.status       = (phase_next == PH_HALT) ? error_code_next : ST_RUN;
      item.found        = found_flag_next;
      item.found_index  = found_flag_next ? found_src_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_size     <= '0;
      find_pos     <= '0;
      locate_only  <= 1'b0;
      phase        <= PH_TOKEN;
      literal_left <= '0;
      match_left   <= '0;
      match_nibble <= '0;
      back_offset  <= '0;
      out_count    <= '0;
      in_count     <= '0;
      found_flag   <= 1'b0;
      found_src    <= '0;
      error_code   <= ST_RUN;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_OUT_SIZE: out_size <= cfg_data[CW-1:0];
          CFG_FIND_POS: find_pos <= cfg_data[FIND_BITS-1:0];
          CFG_LOCATE:   locate_only <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        phase        <= phase_next;
        literal_left <= literal_left_next;
        match_left   <= match_left_next;
        match_nibble <= match_nibble_next;
        back_offset  <= back_offset_next;
        out_count    <= out_count_next;
        in_count     <= in_count_next;
        found_flag   <= found_flag_next;
        found_src    <= found_src_next;
        error_code   <= error_code_next;
      end
    end
  end
endmodule

// ===== rtl/core/lz4_block_decoder_core.sv =====
// Top level of the LZ4 block decoder: control stage, history RAM, read-out
// stage and output register. Depends on lz4bd_pkg, the channel interfaces,
// lz4bd_ctrl and lz4bd_ram.
//
//   channel | kind      | carries
//   req     | sink      | func, in_byte
//   rsp     | source    | out_byte, out_valid, copy_pending, status, found,
//           |           | found_index, block_done
//   cfg     | write     | cfg_we, cfg_addr, cfg_data
//
// One item per cycle unless rsp stalls; each result passes the s2 and output
// registers. The 64 KiB history RAM is read when a tick is taken and its byte
// is used in s2; a copy at distance one is forwarded from the byte being written
// back. Reset (synchronous) clears control state only, history needs no
// clearing pass. A stall on rsp holds rsp, and s2 and req while s2 is full.
module lz4_block_decoder_core (
  input  logic                           clk,
  input  logic                           rst,
  lz4bd_req_if.sink                      req,
  lz4bd_rsp_if.source                    rsp,
  input  logic                           cfg_we,
  input  lz4bd_pkg::cfg_idx_t            cfg_addr,
  input  logic [lz4bd_pkg::CFG_BITS-1:0] cfg_data
);
  import lz4bd_pkg::*;

  item_t      item, s2;
  logic       accept, s2_valid, s2_adv, s2_emit, fwd, s2_fwd;
  logic [7:0] rdata, s2_byte, s2_fbyte;

  assign s2_adv     = !rsp.valid || rsp.ready;
  assign req.ready  = !s2_valid || s2_adv;
  assign accept     = req.valid && req.ready;
  assign s2_emit    = s2_valid && (s2.emit_lit || s2.emit_match);
  assign s2_byte    = s2_fwd ? s2_fbyte : (s2.emit_match ? rdata : s2.lit_byte);
  assign fwd        = item.emit_match && s2_emit && (s2.wr_addr == item.rd_addr);

  lz4bd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .func     (req.func),
    .in_byte  (req.in_byte),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .item     (item)
  );

  lz4bd_ram #(.WIDTH(8), .DEPTH(HIST_BYTES)) u_hist (
    .clk   (clk),
    .we    (s2_emit && s2_adv),
    .waddr (s2.wr_addr),
    .wdata (s2_byte),
    .re    (accept && item.emit_match),
    .raddr (item.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (req.ready) s2_valid <= accept;
      if (s2_adv) rsp.valid <= s2_valid;
    end
    if (accept) begin
      s2       <= item;
      s2_fwd   <= fwd;
      s2_fbyte <= s2_byte;
    end
    if (s2_adv) begin
      rsp.out_byte     <= (s2.emit_lit || s2.emit_match) ? s2_byte : 8'h00;
      rsp.out_valid    <= s2.emit_lit || s2.emit_match;
      rsp.copy_pending <= s2.copy_pending;
      rsp.status       <= s2.status;
      rsp.found        <= s2.found;
      rsp.found_index  <= s2.found_index;
      rsp.block_done   <= s2.block_done;
    end
  end
endmodule

// ===== rtl/core/lz4bd_checker.sv =====
// Port-level checks for the LZ4 block decoder, bound to the top level.
// Depends on lz4bd_pkg and lz4_block_decoder_core.
module lz4bd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            valid,
  input logic [7:0]                      out_byte,
  input logic                            out_valid,
  input logic                            copy_pending,
  input logic [2:0]                      status,
  input logic                            found,
  input logic [lz4bd_pkg::FIND_BITS-1:0] found_index,
  input logic                            block_done
);
  import lz4bd_pkg::*;

  a_rst_clears: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !out_valid |-> out_byte == 8'h00)
    else $error("out_byte nonzero without a decoded byte");
  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    valid && block_done |-> !out_valid && !copy_pending)
    else $error("block end carries data or pending copy");
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !found |-> found_index == '0)
    else $error("found_index set without found");
  a_pending_run: assert property (@(posedge clk) disable iff (rst)
    valid && copy_pending |-> status == 3'(ST_RUN))
    else $error("copy pending with a final status");
endmodule

bind lz4_block_decoder_core lz4bd_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .valid        (rsp.valid),
  .out_byte     (rsp.out_byte),
  .out_valid    (rsp.out_valid),
  .copy_pending (rsp.copy_pending),
  .status       (rsp.status),
  .found        (rsp.found),
  .found_index  (rsp.found_index),
  .block_done   (rsp.block_done)
);
